@@ hw/rtl/mfre_pkg.sv @@
// mfre_pkg: shared constants, types and helpers of the framebuffer raster engine
// depends on nothing; used by mfre_shape, mono_framebuffer_raster_engine and the bench
`timescale 1ns / 1ps

package mfre_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int STORE_DEPTH   = 1024;
  localparam int ADDR_W        = 10;
  localparam int PXA_W         = 13;
  localparam int BYTE_LIMIT_RAW = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
  localparam int BYTE_LIMIT    = (BYTE_LIMIT_RAW > STORE_DEPTH) ? STORE_DEPTH : BYTE_LIMIT_RAW;

  // command codes
  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_SET   = 3'd1;
  localparam logic [2:0] CMD_GET   = 3'd2;
  localparam logic [2:0] CMD_LINE  = 3'd3;
  localparam logic [2:0] CMD_RECT  = 3'd4;
  localparam logic [2:0] CMD_CIRC  = 3'd5;
  localparam logic [2:0] CMD_BYTE  = 3'd6;

  // pixel operation codes
  localparam logic [1:0] COL_WHITE  = 2'd0;
  localparam logic [1:0] COL_BLACK  = 2'd1;
  localparam logic [1:0] COL_INVERT = 2'd2;

  typedef logic signed [9:0] coord_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] x_a;
    logic [7:0] y_a;
    logic [7:0] x_b;
    logic [7:0] y_b;
    logic [7:0] extent_w;
    logic [7:0] extent_h;
    logic [7:0] radius;
    logic [1:0] color;
    logic       filled;
    logic [9:0] byte_index;
  } req_t;

  typedef struct packed {
    logic       status;
    logic       pixel_value;
    logic [7:0] byte_value;
  } res_t;

  // one run of pixels along a row (horiz) or a column
  typedef struct packed {
    logic   horiz;
    coord_t fixed;
    coord_t lo;
    coord_t hi;
  } span_t;

  typedef enum logic [2:0] {
    SH_IDLE, SH_LINE, SH_RECT, SH_CIRC, SH_FIN
  } sh_state_e;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SPAN, ST_PX_RD, ST_PX_WR, ST_RD, ST_RD_DATA, ST_DONE
  } top_state_e;

  // byte address of a pixel, page times width plus column
  function automatic logic [PXA_W-1:0] px_addr(logic [7:0] x, logic [7:0] y);
    px_addr = {5'b0, x} + PXA_W'(y[7:3]) * PXA_W'(SCREEN_WIDTH);
  endfunction

  // apply a pixel operation to a stored byte
  function automatic logic [7:0] px_apply(logic [7:0] d, logic [2:0] bitn, logic [1:0] col);
    logic [7:0] m;
    m = 8'(1) << bitn;
    case (col)
      COL_WHITE:  px_apply = d | m;
      COL_BLACK:  px_apply = d & ~m;
      COL_INVERT: px_apply = d ^ m;
      default:    px_apply = d;
    endcase
  endfunction

endpackage

@@ hw/rtl/mfre_ram.sv @@
// mfre_ram: generic single-clock RAM, one write port, one read port, registered read
// depends on nothing
`timescale 1ns / 1ps

module mfre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/mfre_shape.sv @@
// mfre_shape: turns line, rectangle and circle requests into a sequence of spans
// depends on mfre_pkg
`timescale 1ns / 1ps

module mfre_shape (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  mfre_pkg::req_t req_i,
  output mfre_pkg::span_t span_o,
  output logic           span_valid_o,
  input  logic           span_ready_i,
  output logic           done_o
);

  mfre_pkg::sh_state_e state_q, state_d;
  logic [2:0] idx_q, idx_d;
  logic       fill_q, fill_d;

  // line walker
  logic [7:0] lx_q, lx_d, ly_q, ly_d, lx1_q, lx1_d, ly1_q, ly1_d;
  logic [7:0] dx_q, dx_d, dy_q, dy_d;
  logic       sx_q, sx_d, sy_q, sy_d;
  logic signed [10:0] lerr_q, lerr_d;

  // rectangle
  logic [7:0] rx_q, rx_d, ry_q, ry_d, rxe_q, rxe_d, rye_q, rye_d, row_q, row_d;

  // circle
  logic [7:0] cx_q, cx_d, cy_q, cy_d;
  mfre_pkg::coord_t ca_q, ca_d, cb_q, cb_d;
  logic signed [12:0] cerr_q, cerr_d;

  logic        take;
  logic        line_end;
  logic        last_idx;
  logic signed [11:0] e2;
  logic        step_x, step_y;
  logic [8:0]  xe_sum, ye_sum;
  mfre_pkg::coord_t cxs, cys, cb1, ca1;
  logic signed [12:0] ce1, ct;
  logic        ca_dec;

  assign take     = span_valid_o & span_ready_i;
  assign line_end = (lx_q == lx1_q) && (ly_q == ly1_q);
  assign last_idx = fill_q ? (idx_q == 3'd3) : (idx_q == 3'd7);
  assign e2       = 12'(lerr_q) <<< 1;
  assign step_x   = e2 > -$signed({4'b0, dy_q});
  assign step_y   = e2 < $signed({4'b0, dx_q});
  assign xe_sum   = {1'b0, req_i.x_a} + {1'b0, req_i.extent_w} - 9'd1;
  assign ye_sum   = {1'b0, req_i.y_a} + {1'b0, req_i.extent_h} - 9'd1;
  assign cxs      = mfre_pkg::coord_t'({2'b0, cx_q});
  assign cys      = mfre_pkg::coord_t'({2'b0, cy_q});

  // midpoint error update
  always_comb begin
    cb1    = cb_q + 10'sd1;
    ce1    = cerr_q + 13'sd1 + (13'(cb1) <<< 1);
    ct     = ((ce1 - 13'(ca_q)) <<< 1) + 13'sd1;
    ca_dec = ct > 13'sd0;
    ca1    = ca_dec ? ca_q - 10'sd1 : ca_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mfre_pkg::SH_IDLE: begin
        if (start_i) begin
          case (req_i.command)
            mfre_pkg::CMD_LINE: state_d = mfre_pkg::SH_LINE;
            mfre_pkg::CMD_RECT: state_d = (req_i.extent_w == 8'd0 || req_i.extent_h == 8'd0)
                                          ? mfre_pkg::SH_FIN : mfre_pkg::SH_RECT;
            mfre_pkg::CMD_CIRC: state_d = mfre_pkg::SH_CIRC;
            default:            state_d = mfre_pkg::SH_FIN;
          endcase
        end
      end
      mfre_pkg::SH_LINE: begin
        if (take && line_end) state_d = mfre_pkg::SH_FIN;
      end
      mfre_pkg::SH_RECT: begin
        if (take) begin
          if (fill_q ? (row_q == rye_q) : (idx_q == 3'd3)) state_d = mfre_pkg::SH_FIN;
        end
      end
      mfre_pkg::SH_CIRC: begin
        if (take && last_idx && !(ca1 >= cb1)) state_d = mfre_pkg::SH_FIN;
      end
      // hold done until the pixel walker is back and sees it
      mfre_pkg::SH_FIN: state_d = span_ready_i ? mfre_pkg::SH_IDLE : mfre_pkg::SH_FIN;
      default:          state_d = mfre_pkg::SH_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    span_valid_o = 1'b0;
    done_o       = 1'b0;
    span_o       = '0;
    case (state_q)
      mfre_pkg::SH_LINE: begin
        span_valid_o = 1'b1;
        span_o = '{1'b1, mfre_pkg::coord_t'({2'b0, ly_q}),
                 mfre_pkg::coord_t'({2'b0, lx_q}), mfre_pkg::coord_t'({2'b0, lx_q})};
      end
      mfre_pkg::SH_RECT: begin
        span_valid_o = 1'b1;
        if (fill_q) begin
          span_o = '{1'b1, mfre_pkg::coord_t'({2'b0, row_q}),
                   mfre_pkg::coord_t'({2'b0, rx_q}), mfre_pkg::coord_t'({2'b0, rxe_q})};
        end else begin
          case (idx_q[1:0])
            2'd0: span_o = '{1'b1, mfre_pkg::coord_t'({2'b0, ry_q}),
                             mfre_pkg::coord_t'({2'b0, rx_q}), mfre_pkg::coord_t'({2'b0, rxe_q})};
            2'd1: span_o = '{1'b1, mfre_pkg::coord_t'({2'b0, rye_q}),
                             mfre_pkg::coord_t'({2'b0, rx_q}), mfre_pkg::coord_t'({2'b0, rxe_q})};
            2'd2: span_o = '{1'b0, mfre_pkg::coord_t'({2'b0, rx_q}),
                             mfre_pkg::coord_t'({2'b0, ry_q}), mfre_pkg::coord_t'({2'b0, rye_q})};
            default: span_o = '{1'b0, mfre_pkg::coord_t'({2'b0, rxe_q}),
                             mfre_pkg::coord_t'({2'b0, ry_q}), mfre_pkg::coord_t'({2'b0, rye_q})};
          endcase
        end
      end
      mfre_pkg::SH_CIRC: begin
        span_valid_o = 1'b1;
        if (fill_q) begin
          case (idx_q[1:0])
            2'd0:    span_o = '{1'b1, cys + cb_q, cxs - ca_q, cxs + ca_q};
            2'd1:    span_o = '{1'b1, cys - cb_q, cxs - ca_q, cxs + ca_q};
            2'd2:    span_o = '{1'b1, cys + ca_q, cxs - cb_q, cxs + cb_q};
            default: span_o = '{1'b1, cys - ca_q, cxs - cb_q, cxs + cb_q};
          endcase
        end else begin
          case (idx_q)
            3'd0:    span_o = '{1'b1, cys + cb_q, cxs + ca_q, cxs + ca_q};
            3'd1:    span_o = '{1'b1, cys + cb_q, cxs - ca_q, cxs - ca_q};
            3'd2:    span_o = '{1'b1, cys - cb_q, cxs + ca_q, cxs + ca_q};
            3'd3:    span_o = '{1'b1, cys - cb_q, cxs - ca_q, cxs - ca_q};
            3'd4:    span_o = '{1'b1, cys + ca_q, cxs + cb_q, cxs + cb_q};
            3'd5:    span_o = '{1'b1, cys + ca_q, cxs - cb_q, cxs - cb_q};
            3'd6:    span_o = '{1'b1, cys - ca_q, cxs + cb_q, cxs + cb_q};
            default: span_o = '{1'b1, cys - ca_q, cxs - cb_q, cxs - cb_q};
          endcase
        end
      end
      mfre_pkg::SH_FIN: done_o = 1'b1;
      default: ;
    endcase
  end

  // walker datapath
  always_comb begin
    idx_d = idx_q;  fill_d = fill_q;
    lx_d = lx_q;  ly_d = ly_q;  lx1_d = lx1_q;  ly1_d = ly1_q;
    dx_d = dx_q;  dy_d = dy_q;  sx_d = sx_q;  sy_d = sy_q;  lerr_d = lerr_q;
    rx_d = rx_q;  ry_d = ry_q;  rxe_d = rxe_q;  rye_d = rye_q;  row_d = row_q;
    cx_d = cx_q;  cy_d = cy_q;  ca_d = ca_q;  cb_d = cb_q;  cerr_d = cerr_q;
    if (state_q == mfre_pkg::SH_IDLE && start_i) begin
      idx_d  = 3'd0;
      fill_d = req_i.filled;
      lx_d   = req_i.x_a;  ly_d = req_i.y_a;
      lx1_d  = req_i.x_b;  ly1_d = req_i.y_b;
      sx_d   = req_i.x_a < req_i.x_b;
      sy_d   = req_i.y_a < req_i.y_b;
      dx_d   = sx_d ? req_i.x_b - req_i.x_a : req_i.x_a - req_i.x_b;
      dy_d   = sy_d ? req_i.y_b - req_i.y_a : req_i.y_a - req_i.y_b;
      lerr_d = $signed({3'b0, dx_d}) - $signed({3'b0, dy_d});
      rx_d   = req_i.x_a;  ry_d = req_i.y_a;  row_d = req_i.y_a;
      rxe_d  = xe_sum[8] ? 8'd255 : xe_sum[7:0];
      rye_d  = ye_sum[8] ? 8'd255 : ye_sum[7:0];
      cx_d   = req_i.x_a;  cy_d = req_i.y_a;
      ca_d   = mfre_pkg::coord_t'({2'b0, req_i.radius});
      cb_d   = '0;
      cerr_d = '0;
    end else if (take) begin
      case (state_q)
        mfre_pkg::SH_LINE: begin
          lx_d   = step_x ? (sx_q ? lx_q + 8'd1 : lx_q - 8'd1) : lx_q;
          ly_d   = step_y ? (sy_q ? ly_q + 8'd1 : ly_q - 8'd1) : ly_q;
          lerr_d = lerr_q - (step_x ? $signed({3'b0, dy_q}) : 11'sd0)
                          + (step_y ? $signed({3'b0, dx_q}) : 11'sd0);
        end
        mfre_pkg::SH_RECT: begin
          row_d = row_q + 8'd1;
          idx_d = idx_q + 3'd1;
        end
        mfre_pkg::SH_CIRC: begin
          if (last_idx) begin
            idx_d  = 3'd0;
            cb_d   = cb1;
            ca_d   = ca1;
            cerr_d = ca_dec ? ce1 + 13'sd1 - (13'(ca1) <<< 1) : ce1;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfre_pkg::SH_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // walker registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;  fill_q <= fill_d;
    lx_q <= lx_d;  ly_q <= ly_d;  lx1_q <= lx1_d;  ly1_q <= ly1_d;
    dx_q <= dx_d;  dy_q <= dy_d;  sx_q <= sx_d;  sy_q <= sy_d;  lerr_q <= lerr_d;
    rx_q <= rx_d;  ry_q <= ry_d;  rxe_q <= rxe_d;  rye_q <= rye_d;  row_q <= row_d;
    cx_q <= cx_d;  cy_q <= cy_d;  ca_q <= ca_d;  cb_q <= cb_d;  cerr_q <= cerr_d;
  end

endmodule

@@ hw/rtl/mono_framebuffer_raster_engine.sv @@
// mono_framebuffer_raster_engine: 1-bit framebuffer with pixel, line, rectangle and circle
// drawing; depends on mfre_pkg, mfre_ram and mfre_shape
// each request ends in a result strobe; drawing walks each clipped span pixel by pixel,
// reading then writing each pixel's byte; rejected or unknown requests go straight to the strobe
// busy is high through the strobe cycle, next request in the cycle after; receiver cannot stall
// reset starts a clearing pass over all 1024 bytes, busy high throughout it
`timescale 1ns / 1ps

module mono_framebuffer_raster_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  mfre_pkg::req_t req_i,
  output logic           valid_o,
  output mfre_pkg::res_t res_o
);

  mfre_pkg::top_state_e state_q, state_d;
  mfre_pkg::req_t req_q, req_d;
  mfre_pkg::res_t res_q, res_d;
  logic [mfre_pkg::ADDR_W-1:0] clr_cnt_q, clr_cnt_d, rd_addr_q, rd_addr_d, wa_q, wa_d;
  logic       clr_cmd_q, clr_cmd_d;
  logic [7:0] px_x_q, px_x_d, px_y_q, px_y_d, end_q, end_d;
  logic       horiz_q, horiz_d, ok_q, ok_d;

  logic accept;
  logic shp_start, shp_valid, shp_ready, shp_done;
  mfre_pkg::span_t span;
  logic [mfre_pkg::PXA_W-1:0] in_addr, cur_addr;
  logic in_ok, byte_ok, walk_end;
  logic f_ok, span_go;
  mfre_pkg::coord_t lim, flim, lo_c, hi_c;

  logic       we;
  logic [mfre_pkg::ADDR_W-1:0] waddr, raddr;
  logic [7:0] wdata, rdata;

  assign accept    = start && !busy;
  assign shp_start = accept && (req_i.command == mfre_pkg::CMD_LINE ||
                                req_i.command == mfre_pkg::CMD_RECT ||
                                req_i.command == mfre_pkg::CMD_CIRC);
  assign shp_ready = (state_q == mfre_pkg::ST_SPAN);

  // request checks
  assign in_addr = mfre_pkg::px_addr(req_i.x_a, req_i.y_a);
  assign in_ok   = ({1'b0, req_i.x_a} < 9'(mfre_pkg::SCREEN_WIDTH)) &&
                   ({1'b0, req_i.y_a} < 9'(mfre_pkg::SCREEN_HEIGHT)) &&
                   (in_addr < mfre_pkg::PXA_W'(mfre_pkg::STORE_DEPTH));
  assign byte_ok = {1'b0, req_i.byte_index} < 11'(mfre_pkg::BYTE_LIMIT);
  assign cur_addr = mfre_pkg::px_addr(px_x_q, px_y_q);
  assign walk_end = (horiz_q ? px_x_q : px_y_q) == end_q;

  // span clipping
  always_comb begin
    lim     = span.horiz ? mfre_pkg::coord_t'(mfre_pkg::SCREEN_WIDTH)
                         : mfre_pkg::coord_t'(mfre_pkg::SCREEN_HEIGHT);
    flim    = span.horiz ? mfre_pkg::coord_t'(mfre_pkg::SCREEN_HEIGHT)
                         : mfre_pkg::coord_t'(mfre_pkg::SCREEN_WIDTH);
    f_ok    = (span.fixed >= 10'sd0) && (span.fixed < flim);
    lo_c    = (span.lo < 10'sd0) ? 10'sd0 : span.lo;
    hi_c    = (span.hi > lim - 10'sd1) ? lim - 10'sd1 : span.hi;
    span_go = shp_valid && f_ok && (lo_c <= hi_c);
  end

  mfre_shape u_shape (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (shp_start),
    .req_i        (req_i),
    .span_o       (span),
    .span_valid_o (shp_valid),
    .span_ready_i (shp_ready),
    .done_o       (shp_done)
  );

  mfre_ram #(
    .WIDTH (8),
    .DEPTH (mfre_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mfre_pkg::ST_CLEAR: begin
        if (clr_cnt_q == mfre_pkg::ADDR_W'(mfre_pkg::STORE_DEPTH - 1)) begin
          state_d = clr_cmd_q ? mfre_pkg::ST_DONE : mfre_pkg::ST_IDLE;
        end
      end
      mfre_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_i.command)
            mfre_pkg::CMD_CLEAR: state_d = mfre_pkg::ST_CLEAR;
            mfre_pkg::CMD_SET:   state_d = in_ok ? mfre_pkg::ST_PX_RD : mfre_pkg::ST_DONE;
            mfre_pkg::CMD_GET:   state_d = in_ok ? mfre_pkg::ST_RD : mfre_pkg::ST_DONE;
            mfre_pkg::CMD_BYTE:  state_d = byte_ok ? mfre_pkg::ST_RD : mfre_pkg::ST_DONE;
            mfre_pkg::CMD_LINE,
            mfre_pkg::CMD_RECT,
            mfre_pkg::CMD_CIRC:  state_d = mfre_pkg::ST_SPAN;
            default:             state_d = mfre_pkg::ST_DONE;
          endcase
        end
      end
      mfre_pkg::ST_SPAN: begin
        if (shp_done)     state_d = mfre_pkg::ST_DONE;
        else if (span_go) state_d = mfre_pkg::ST_PX_RD;
      end
      mfre_pkg::ST_PX_RD: state_d = mfre_pkg::ST_PX_WR;
      mfre_pkg::ST_PX_WR: begin
        if (!walk_end)                             state_d = mfre_pkg::ST_PX_RD;
        else if (req_q.command == mfre_pkg::CMD_SET) state_d = mfre_pkg::ST_DONE;
        else                                       state_d = mfre_pkg::ST_SPAN;
      end
      mfre_pkg::ST_RD:      state_d = mfre_pkg::ST_RD_DATA;
      mfre_pkg::ST_RD_DATA: state_d = mfre_pkg::ST_DONE;
      mfre_pkg::ST_DONE:    state_d = mfre_pkg::ST_IDLE;
      default:              state_d = mfre_pkg::ST_IDLE;
    endcase
  end

  // outputs and store port control
  always_comb begin
    busy    = (state_q != mfre_pkg::ST_IDLE);
    valid_o = (state_q == mfre_pkg::ST_DONE);
    res_o   = res_q;
    we      = 1'b0;
    waddr   = wa_q;
    wdata   = mfre_pkg::px_apply(rdata, px_y_q[2:0], req_q.color);
    raddr   = cur_addr[mfre_pkg::ADDR_W-1:0];
    case (state_q)
      mfre_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt_q;
        wdata = 8'd0;
      end
      mfre_pkg::ST_RD:    raddr = rd_addr_q;
      mfre_pkg::ST_PX_WR: we    = ok_q;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    req_d     = req_q;
    res_d     = res_q;
    clr_cnt_d = clr_cnt_q;
    clr_cmd_d = clr_cmd_q;
    rd_addr_d = rd_addr_q;
    wa_d      = wa_q;
    ok_d      = ok_q;
    px_x_d    = px_x_q;
    px_y_d    = px_y_q;
    end_d     = end_q;
    horiz_d   = horiz_q;
    case (state_q)
      mfre_pkg::ST_CLEAR: clr_cnt_d = clr_cnt_q + 1'b1;
      mfre_pkg::ST_IDLE: begin
        if (accept) begin
          req_d     = req_i;
          res_d     = '0;
          clr_cnt_d = '0;
          clr_cmd_d = 1'b1;
          px_x_d    = req_i.x_a;
          px_y_d    = req_i.y_a;
          end_d     = req_i.x_a;
          horiz_d   = 1'b1;
          rd_addr_d = (req_i.command == mfre_pkg::CMD_BYTE) ? req_i.byte_index
                                                            : in_addr[mfre_pkg::ADDR_W-1:0];
          if ((req_i.command == mfre_pkg::CMD_SET || req_i.command == mfre_pkg::CMD_GET)
              && !in_ok) begin
            res_d.status = 1'b1;
          end
          if (req_i.command == mfre_pkg::CMD_BYTE && !byte_ok) begin
            res_d.status = 1'b1;
          end
        end
      end
      mfre_pkg::ST_SPAN: begin
        if (span_go) begin
          horiz_d = span.horiz;
          end_d   = hi_c[7:0];
          px_x_d  = span.horiz ? lo_c[7:0] : span.fixed[7:0];
          px_y_d  = span.horiz ? span.fixed[7:0] : lo_c[7:0];
        end
      end
      mfre_pkg::ST_PX_RD: begin
        wa_d = cur_addr[mfre_pkg::ADDR_W-1:0];
        ok_d = cur_addr < mfre_pkg::PXA_W'(mfre_pkg::STORE_DEPTH);
      end
      mfre_pkg::ST_PX_WR: begin
        if (!walk_end) begin
          if (horiz_q) px_x_d = px_x_q + 8'd1;
          else         px_y_d = px_y_q + 8'd1;
        end
      end
      mfre_pkg::ST_RD_DATA: begin
        if (req_q.command == mfre_pkg::CMD_GET) res_d.pixel_value = rdata[req_q.y_a[2:0]];
        else                                    res_d.byte_value  = rdata;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mfre_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
      clr_cmd_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      clr_cmd_q <= clr_cmd_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    res_q     <= res_d;
    rd_addr_q <= rd_addr_d;
    wa_q      <= wa_d;
    ok_q      <= ok_d;
    px_x_q    <= px_x_d;
    px_y_q    <= px_y_d;
    end_q     <= end_d;
    horiz_q   <= horiz_d;
  end

endmodule

@@ tb/sv/tb_mono_framebuffer_raster_engine.sv @@
// tb_mono_framebuffer_raster_engine: self-checking bench for the framebuffer raster engine
// depends on mfre_pkg and mono_framebuffer_raster_engine; a directed table, then random
// commands, each result checked against a table value or a bit-exact framebuffer model
`timescale 1ns / 1ps

module tb_mono_framebuffer_raster_engine;
  import mfre_pkg::*;

  localparam logic [2:0] CMD_NONE = 3'd7;
  localparam logic [1:0] COL_KEEP = 2'd3;
  localparam int RAND_ITEMS = 1925;
  localparam int STALL_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    req_t req;
    bit   known;
    res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic res_valid;
  res_t res;

  logic [7:0] shadow_fb [STORE_DEPTH];
  res_t       pending_q [$];
  int         err_cnt = 0;
  int         quiet_cycles = 0;

  always #5 clk = ~clk;

  mono_framebuffer_raster_engine dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .start   (start),
    .busy    (busy),
    .req_i   (req),
    .valid_o (res_valid),
    .res_o   (res)
  );

  // framebuffer model: one pixel write with clipping
  function automatic void plot(int x, int y, logic [1:0] col);
    int a;
    logic [7:0] m;
    if (x < 0 || y < 0 || x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) return;
    a = x + (y >> 3) * SCREEN_WIDTH;
    if (a >= STORE_DEPTH) return;
    m = 8'(1) << (y & 7);
    case (col)
      COL_WHITE:  shadow_fb[a] = shadow_fb[a] | m;
      COL_BLACK:  shadow_fb[a] = shadow_fb[a] & ~m;
      COL_INVERT: shadow_fb[a] = shadow_fb[a] ^ m;
      default:    ;
    endcase
  endfunction

  function automatic void row_run(int xa, int xb, int y, logic [1:0] col);
    if (y < 0 || y >= SCREEN_HEIGHT) return;
    if (xa < 0) xa = 0;
    if (xb > SCREEN_WIDTH - 1) xb = SCREEN_WIDTH - 1;
    for (int x = xa; x <= xb; x++) plot(x, y, col);
  endfunction

  function automatic void col_run(int x, int ya, int yb, logic [1:0] col);
    if (x < 0 || x >= SCREEN_WIDTH) return;
    if (ya < 0) ya = 0;
    if (yb > SCREEN_HEIGHT - 1) yb = SCREEN_HEIGHT - 1;
    for (int y = ya; y <= yb; y++) plot(x, y, col);
  endfunction

  // bresenham walk from (x0,y0) to (x1,y1)
  function automatic void draw_segment(int x0, int y0, int x1, int y1, logic [1:0] col);
    int dx, dy, sx, sy, err, e2;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx - dy;
    forever begin
      plot(x0, y0, col);
      if (x0 == x1 && y0 == y1) break;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x0 += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y0 += sy;
      end
    end
  endfunction

  // rectangle with right and bottom edges stopping at 255
  function automatic void draw_box(int x, int y, int w, int h, logic [1:0] col, bit fill);
    int xe, ye;
    if (w == 0 || h == 0) return;
    xe = (x + w - 1 > 255) ? 255 : x + w - 1;
    ye = (y + h - 1 > 255) ? 255 : y + h - 1;
    if (fill) begin
      for (int r = y; r <= ye; r++) row_run(x, xe, r, col);
    end else begin
      row_run(x, xe, y, col);
      row_run(x, xe, ye, col);
      col_run(x, y, ye, col);
      col_run(xe, y, ye, col);
    end
  endfunction

  // midpoint circle with its own error update
  function automatic void draw_ring(int cx, int cy, int rad, logic [1:0] col, bit fill);
    int a, b, err;
    a = rad;
    b = 0;
    err = 0;
    while (a >= b) begin
      if (fill) begin
        row_run(cx - a, cx + a, cy + b, col);
        row_run(cx - a, cx + a, cy - b, col);
        row_run(cx - b, cx + b, cy + a, col);
        row_run(cx - b, cx + b, cy - a, col);
      end else begin
        plot(cx + a, cy + b, col);
        plot(cx - a, cy + b, col);
        plot(cx + a, cy - b, col);
        plot(cx - a, cy - b, col);
        plot(cx + b, cy + a, col);
        plot(cx - b, cy + a, col);
        plot(cx + b, cy - a, col);
        plot(cx - b, cy - a, col);
      end
      b++;
      err += 1 + 2 * b;
      if (2 * (err - a) + 1 > 0) begin
        a--;
        err += 1 - 2 * a;
      end
    end
  endfunction

  // run one request on the model, return the expected result
  function automatic res_t raster_expect(req_t r);
    res_t e;
    int a;
    e = '0;
    case (r.command)
      CMD_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = '0;
      CMD_SET, CMD_GET: begin
        a = int'(r.x_a) + int'(r.y_a >> 3) * SCREEN_WIDTH;
        if (r.x_a >= SCREEN_WIDTH || r.y_a >= SCREEN_HEIGHT || a >= STORE_DEPTH)
          e.status = 1'b1;
        else if (r.command == CMD_SET)
          plot(r.x_a, r.y_a, r.color);
        else
          e.pixel_value = shadow_fb[a][r.y_a[2:0]];
      end
      CMD_LINE: draw_segment(r.x_a, r.y_a, r.x_b, r.y_b, r.color);
      CMD_RECT: draw_box(r.x_a, r.y_a, r.extent_w, r.extent_h, r.color, r.filled);
      CMD_CIRC: draw_ring(r.x_a, r.y_a, r.radius, r.color, r.filled);
      CMD_BYTE: begin
        if (r.byte_index < BYTE_LIMIT) e.byte_value = shadow_fb[r.byte_index];
        else e.status = 1'b1;
      end
      default: ;
    endcase
    return e;
  endfunction

  function automatic req_t mk(logic [2:0] cmd, int xa, int ya, int xb, int yb, int w, int h,
                              int rad, logic [1:0] col, bit fill, int bidx);
    req_t r;
    r.command = cmd;
    r.x_a = 8'(xa);
    r.y_a = 8'(ya);
    r.x_b = 8'(xb);
    r.y_b = 8'(yb);
    r.extent_w = 8'(w);
    r.extent_h = 8'(h);
    r.radius = 8'(rad);
    r.color = col;
    r.filled = fill;
    r.byte_index = 10'(bidx);
    return r;
  endfunction

  // coordinates mostly on or near the screen, sometimes anywhere
  function automatic logic [7:0] pick_x();
    return ($urandom_range(9) < 8) ? 8'($urandom_range(SCREEN_WIDTH + 7)) : 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_y();
    return ($urandom_range(9) < 8) ? 8'($urandom_range(SCREEN_HEIGHT + 7)) : 8'($urandom);
  endfunction

  // sizes mostly small so the run stays short, rarely full range
  function automatic logic [7:0] pick_size();
    return ($urandom_range(99) < 2) ? 8'($urandom) : 8'($urandom_range(20));
  endfunction

  function automatic req_t random_request();
    req_t r;
    int v;
    r = req_t'({$urandom, $urandom, $urandom});
    v = $urandom_range(99);
    if (v < 3) r.command = CMD_CLEAR;
    else if (v < 23) r.command = CMD_SET;
    else if (v < 38) r.command = CMD_GET;
    else if (v < 53) r.command = CMD_LINE;
    else if (v < 68) r.command = CMD_RECT;
    else if (v < 80) r.command = CMD_CIRC;
    else if (v < 97) r.command = CMD_BYTE;
    else r.command = CMD_NONE;
    r.x_a = pick_x();
    r.y_a = pick_y();
    r.x_b = pick_x();
    r.y_b = pick_y();
    r.extent_w = pick_size();
    r.extent_h = pick_size();
    r.radius = pick_size();
    r.color = ($urandom_range(9) == 0) ? COL_KEEP : 2'($urandom_range(2));
    return r;
  endfunction

  // hand one request over, idling first with the given odds
  task automatic issue(req_t r, int idle_pct, bit known, res_t given);
    res_t e;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    e = raster_expect(r);
    pending_q.push_back(known ? given : e);
  endtask

  // result checker
  always @(posedge clk) begin
    res_t e;
    if (rst_n && res_valid) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with no request waiting: %p", $time, res);
        err_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (res.status !== e.status)
          $display("%0t: status exp %0d act %0d", $time, e.status, res.status);
        if (res.pixel_value !== e.pixel_value)
          $display("%0t: pixel_value exp %0d act %0d", $time, e.pixel_value, res.pixel_value);
        if (res.byte_value !== e.byte_value)
          $display("%0t: byte_value exp %02h act %02h", $time, e.byte_value, res.byte_value);
        if (res !== e) err_cnt++;
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((start && !busy) || res_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL mono_framebuffer_raster_engine");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    int   phase_idle [4];
    foreach (shadow_fb[i]) shadow_fb[i] = '0;
    phase_idle = '{0, 66, 28, 0};

    // directed table
    rows.push_back('{mk(CMD_GET, 0, 0, 0, 0, 0, 0, 0, COL_WHITE, 0, 0), 1, 10'h000});
    rows.push_back('{mk(CMD_BYTE, 0, 0, 0, 0, 0, 0, 0, COL_WHITE, 0, 0), 1, 10'h000});
    rows.push_back('{mk(CMD_BYTE, 0, 0, 0, 0, 0, 0, 0, COL_WHITE, 0, 1023), 1, 10'h000});
    rows.push_back('{mk(CMD_SET, 127, 63, 0, 0, 0, 0, 0, COL_WHITE, 0, 0), 1, 10'h000});
    rows.push_back('{mk(CMD_GET, 127, 63, 0, 0, 0, 0, 0, COL_WHITE, 0, 0), 1, 10'h100});
    rows.push_back('{mk(CMD_BYTE, 0, 0, 0, 0, 0, 0, 0, COL_WHITE, 0, 1023), 1, 10'h080});
    rows.push_back('{mk(CMD_SET, 128, 0, 0, 0, 0, 0, 0, COL_WHITE, 0, 0), 1, 10'h200});
    rows.push_back('{mk(CMD_GET, 0, 64, 0, 0, 0, 0, 0, COL_WHITE, 0, 0), 1, 10'h200});
    rows.push_back('{mk(CMD_SET, 255, 255, 255, 255, 255, 255, 255, COL_KEEP, 1, 1023),
                     1, 10'h200});
    rows.push_back('{mk(CMD_SET, 5, 9, 0, 0, 0, 0, 0, COL_INVERT, 0, 0), 1, 10'h000});
    rows.push_back('{mk(CMD_GET, 5, 9, 0, 0, 0, 0, 0, COL_WHITE, 0, 0), 1, 10'h100});
    rows.push_back('{mk(CMD_SET, 5, 9, 0, 0, 0, 0, 0, COL_INVERT, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_GET, 5, 9, 0, 0, 0, 0, 0, COL_WHITE, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_LINE, 0, 0, 255, 255, 0, 0, 0, COL_WHITE, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_LINE, 127, 63, 0, 0, 0, 0, 0, COL_INVERT, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_LINE, 9, 9, 9, 9, 0, 0, 0, COL_WHITE, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_RECT, 250, 250, 0, 0, 255, 255, 0, COL_WHITE, 1, 0), 0, '0});
    rows.push_back('{mk(CMD_RECT, 10, 10, 0, 0, 0, 5, 0, COL_WHITE, 1, 0), 0, '0});
    rows.push_back('{mk(CMD_RECT, 10, 10, 0, 0, 5, 0, 0, COL_WHITE, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_RECT, 0, 0, 0, 0, 128, 64, 0, COL_INVERT, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_RECT, 3, 3, 0, 0, 20, 20, 0, COL_KEEP, 1, 0), 0, '0});
    rows.push_back('{mk(CMD_CIRC, 64, 32, 0, 0, 0, 0, 40, COL_BLACK, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_CIRC, 0, 0, 0, 0, 0, 0, 255, COL_INVERT, 1, 0), 0, '0});
    rows.push_back('{mk(CMD_CIRC, 100, 20, 0, 0, 0, 0, 0, COL_WHITE, 1, 0), 0, '0});
    rows.push_back('{mk(CMD_BYTE, 0, 0, 0, 0, 0, 0, 0, COL_WHITE, 0, 130), 0, '0});
    rows.push_back('{mk(CMD_NONE, 7, 7, 7, 7, 7, 7, 7, COL_WHITE, 1, 7), 1, 10'h000});
    rows.push_back('{mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, COL_WHITE, 0, 0), 1, 10'h000});
    rows.push_back('{mk(CMD_BYTE, 0, 0, 0, 0, 0, 0, 0, COL_WHITE, 0, 1023), 1, 10'h000});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) issue(rows[i].req, 0, rows[i].known, rows[i].res);

    // random commands in phases of sender idling
    for (int p = 0; p < 4; p++) begin
      for (int n = 0; n < RAND_ITEMS / 4; n++) begin
        issue(random_request(), phase_idle[p], 0, '0);
        // hold off until the engine has drained
        if (p == 1 && n == 100) begin
          start <= 1'b0;
          while (pending_q.size() != 0) @(posedge clk);
        end
      end
    end

    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending_q.size() == 0)
      $display("PASS mono_framebuffer_raster_engine");
    else
      $display("FAIL mono_framebuffer_raster_engine");
    $finish;
  end

endmodule
